FILE: sv/ogg_pkg.sv
// Shared types and constants of the Ogg page demultiplexer.
package ogg_pkg;

    // Event codes carried in each result item.
    typedef enum logic [1:0] {
        EV_HEADER   = 2'd0,
        EV_PAYLOAD  = 2'd1,
        EV_MISMATCH = 2'd2
    } event_kind_t;

    // One classified item as it travels through the queues.
    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  data;
        logic [7:0]  flags;
        logic [31:0] serial;
        logic [15:0] length;
        logic        matched;
        logic        last;
    } record_t;

    // Fixed page header layout.
    localparam int HDR_IDX_W = 5;
    localparam logic [HDR_IDX_W-1:0] CAPTURE_LAST  = 5'd3;
    localparam logic [HDR_IDX_W-1:0] FLAGS_INDEX   = 5'd5;
    localparam logic [HDR_IDX_W-1:0] SERIAL_FIRST  = 5'd14;
    localparam logic [HDR_IDX_W-1:0] SERIAL_LAST   = 5'd17;
    localparam logic [HDR_IDX_W-1:0] SEGMENT_INDEX = 5'd26;

    // Queue geometry; the depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam logic REG_SELECT_SERIAL = 1'b0;
    localparam logic REG_FILTER_ENABLE = 1'b1;

    // The capture pattern "OggS", one character per position.
    function automatic logic [7:0] capture_byte(input logic [1:0] pos);
        logic [7:0] value;
        case (pos)
            2'd0:    value = 8'h4F;
            2'd1:    value = 8'h67;
            2'd2:    value = 8'h67;
            default: value = 8'h53;
        endcase
        return value;
    endfunction

endpackage

FILE: sv/ogg_queue.sv
// Small first-in first-out queue of classified records.
module ogg_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  ogg_pkg::record_t wr_rec,
    input  logic             rd_en,
    output ogg_pkg::record_t rd_rec,
    output logic             full,
    output logic             empty
);

    ogg_pkg::record_t                   slot_reg [ogg_pkg::QUEUE_DEPTH];
    logic [ogg_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [ogg_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [ogg_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [ogg_pkg::QUEUE_CNT_W-1:0]    count_next;
    logic                               do_wr;
    logic                               do_rd;

    assign full  = (count_reg == ogg_pkg::QUEUE_CNT_W'(ogg_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_rec = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_rec;
        end
    end

endmodule

FILE: sv/ogg_front.sv
// Byte parser: walks the page header and segment table and classifies each item.
module ogg_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       data_byte,
    output logic             rec_valid,
    output ogg_pkg::record_t rec
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SEGMENTS,
        PH_PAYLOAD
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [ogg_pkg::HDR_IDX_W-1:0]   index_reg, index_next;
    logic [7:0]                      seg_reg, seg_next;
    logic [7:0]                      flags_reg, flags_next;
    logic [31:0]                     serial_reg, serial_next;
    logic [15:0]                     length_reg, length_next;
    logic [15:0]                     left_reg, left_next;
    logic                            halted_reg, halted_next;

    logic [15:0]                     left_dec;
    logic [15:0]                     length_sum;
    logic [7:0]                      seg_dec;

    assign left_dec   = left_reg - 16'd1;
    assign length_sum = length_reg + {8'd0, data_byte};
    assign seg_dec    = seg_reg - 8'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        index_next  = index_reg;
        seg_next    = seg_reg;
        flags_next  = flags_reg;
        serial_next = serial_reg;
        length_next = length_reg;
        left_next   = left_reg;
        halted_next = halted_reg;
        rec_valid   = 1'b0;
        rec.kind    = ogg_pkg::EV_HEADER;
        rec.data    = 8'd0;
        rec.flags   = flags_reg;
        rec.serial  = serial_reg;
        rec.length  = length_reg;
        rec.matched = 1'b0;
        rec.last    = 1'b0;

        if (accept && !halted_reg)
        begin
            case (phase_reg)
                PH_PAYLOAD:
                begin
                    left_next = left_dec;
                    rec_valid = 1'b1;
                    rec.kind  = ogg_pkg::EV_PAYLOAD;
                    rec.data  = data_byte;
                    rec.last  = (left_dec == 16'd0);
                    if (left_dec == 16'd0)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_SEGMENTS:
                begin
                    length_next = length_sum;
                    seg_next    = seg_dec;
                    if (seg_dec == 8'd0)
                    begin
                        left_next  = length_sum;
                        index_next = '0;
                        phase_next = (length_sum != 16'd0) ? PH_PAYLOAD : PH_HEADER;
                        rec_valid  = 1'b1;
                        rec.length = length_sum;
                    end
                end
                PH_HEADER:
                begin
                    index_next = index_reg + 1'b1;
                    if (index_reg <= ogg_pkg::CAPTURE_LAST)
                    begin
                        if (data_byte != ogg_pkg::capture_byte(index_reg[1:0]))
                        begin
                            // Lost sync: report once and stop parsing.
                            index_next  = index_reg;
                            halted_next = 1'b1;
                            rec_valid   = 1'b1;
                            rec.kind    = ogg_pkg::EV_MISMATCH;
                            rec.flags   = 8'd0;
                            rec.serial  = 32'd0;
                            rec.length  = 16'd0;
                        end
                    end
                    else if (index_reg == ogg_pkg::FLAGS_INDEX)
                    begin
                        flags_next = data_byte;
                    end
                    else if (index_reg >= ogg_pkg::SERIAL_FIRST &&
                             index_reg <= ogg_pkg::SERIAL_LAST)
                    begin
                        serial_next = {data_byte, serial_reg[31:8]};
                    end
                    else if (index_reg == ogg_pkg::SEGMENT_INDEX)
                    begin
                        seg_next    = data_byte;
                        length_next = 16'd0;
                        index_next  = '0;
                        if (data_byte == 8'd0)
                        begin
                            // A page with no segments has its header done here.
                            left_next  = 16'd0;
                            rec_valid  = 1'b1;
                            rec.length = 16'd0;
                        end
                        else
                        begin
                            phase_next = PH_SEGMENTS;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            index_reg  <= '0;
            seg_reg    <= 8'd0;
            flags_reg  <= 8'd0;
            serial_reg <= 32'd0;
            length_reg <= 16'd0;
            left_reg   <= 16'd0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            seg_reg    <= seg_next;
            flags_reg  <= flags_next;
            serial_reg <= serial_next;
            length_reg <= length_next;
            left_reg   <= left_next;
            halted_reg <= halted_next;
        end
    end

endmodule

FILE: sv/ogg_back.sv
// Serial matcher and payload filter between the two queues.
module ogg_back (
    input  logic             mid_empty,
    input  ogg_pkg::record_t mid_rec,
    input  logic             out_full,
    input  logic [31:0]      select_serial,
    input  logic             filter_enable,
    output logic             mid_pop,
    output logic             out_push,
    output ogg_pkg::record_t out_rec
);

    logic matched;
    logic pass;

    assign matched = (mid_rec.kind != ogg_pkg::EV_MISMATCH) &&
                     (mid_rec.serial == select_serial);

    // Only payload items are ever dropped; headers and errors always go out.
    assign pass = (mid_rec.kind != ogg_pkg::EV_PAYLOAD) || !filter_enable || matched;

    assign mid_pop  = !mid_empty && !out_full;
    assign out_push = mid_pop && pass;

    always_comb
    begin
        out_rec         = mid_rec;
        out_rec.matched = matched;
    end

endmodule

FILE: sv/ogg_page_demux_unit.sv
// Top level of the Ogg page demultiplexer: configuration registers and the parser pipeline.
//
// Container bytes enter one per clock cycle while full is low; every byte, whether or
// not it yields a result, is taken by the header parser, so the sustained rate is one
// byte per cycle. A result item reaches the result ports through both queues: the
// parser writes it into the two-entry queue when its byte is accepted, and the serial
// filter then moves it into the two-entry output queue whenever that queue has room.
// The input stalls only while the parser queue is full, which happens once the output
// queue has been full long enough for the parser queue to fill behind it. Each page
// gives one header item, then one item per passed payload byte; payload of other
// serials is dropped when filtering is enabled. A broken capture pattern gives one
// error item, after which bytes are swallowed until reset. Registers: select_serial at
// address 0, filter_enable at address 4; write them only while the block is idle.
module ogg_page_demux_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ogg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       push,
    output logic                       full,
    input  logic [7:0]                 data_byte,
    output logic                       empty,
    input  logic                       pop,
    output logic [1:0]                 event_kind,
    output logic [7:0]                 payload_byte,
    output logic [7:0]                 header_flags,
    output logic [31:0]                page_serial,
    output logic [15:0]                payload_length,
    output logic                       serial_match,
    output logic                       last_of_page
);

    logic [31:0]      select_serial_reg;
    logic             filter_enable_reg;
    logic             cfg_write;

    logic             accept;
    logic             front_valid;
    ogg_pkg::record_t front_rec;
    logic             mid_full;
    logic             mid_empty;
    logic             mid_pop;
    ogg_pkg::record_t mid_rec;
    logic             out_full;
    logic             out_push;
    ogg_pkg::record_t back_rec;
    ogg_pkg::record_t head_rec;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == ogg_pkg::REG_FILTER_ENABLE) ?
                       {31'd0, filter_enable_reg} : select_serial_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_serial_reg <= 32'd0;
            filter_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == ogg_pkg::REG_SELECT_SERIAL)
            begin
                select_serial_reg <= pwdata;
            end
            else
            begin
                filter_enable_reg <= pwdata[0];
            end
        end
    end

    assign full   = mid_full;
    assign accept = push && !mid_full;

    ogg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .rec_valid (front_valid),
        .rec       (front_rec)
    );

    ogg_queue u_mid_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (front_valid),
        .wr_rec (front_rec),
        .rd_en  (mid_pop),
        .rd_rec (mid_rec),
        .full   (mid_full),
        .empty  (mid_empty)
    );

    ogg_back u_back (
        .mid_empty     (mid_empty),
        .mid_rec       (mid_rec),
        .out_full      (out_full),
        .select_serial (select_serial_reg),
        .filter_enable (filter_enable_reg),
        .mid_pop       (mid_pop),
        .out_push      (out_push),
        .out_rec       (back_rec)
    );

    ogg_queue u_out_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (out_push),
        .wr_rec (back_rec),
        .rd_en  (pop),
        .rd_rec (head_rec),
        .full   (out_full),
        .empty  (empty)
    );

    assign event_kind     = 2'(head_rec.kind);
    assign payload_byte   = head_rec.data;
    assign header_flags   = head_rec.flags;
    assign page_serial    = head_rec.serial;
    assign payload_length = head_rec.length;
    assign serial_match   = head_rec.matched;
    assign last_of_page   = head_rec.last;

endmodule
